/* design/msd_pkg.sv */
// ----------------------------------------------------------------------------
// msd_pkg
// Types, codes and prefix pattern tables for the exclusive message decoder.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int PAT_NUM = 9;
  localparam int PAT_POS = 9;
  localparam int POS_W   = 4;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_RESET  = 2'd1,
    CMD_VOLUME = 2'd2,
    CMD_DRUM   = 2'd3
  } cmd_kind_t;

  typedef enum logic [2:0] {
    MODE_GM1  = 3'd0,
    MODE_GM2  = 3'd1,
    MODE_GS   = 3'd2,
    MODE_SET1 = 3'd3,
    MODE_SET2 = 3'd4,
    MODE_XG   = 3'd5
  } sys_mode_t;

  typedef struct packed {
    logic [PAT_NUM-1:0] alive;
    logic [PAT_NUM-1:0] hit;
  } msd_match_t;

  // Byte positions a pattern reads its captured fields from
  localparam logic [POS_W-1:0] POS_PART   = 4'd5;
  localparam logic [POS_W-1:0] POS_VOLUME = 4'd6;
  localparam logic [POS_W-1:0] POS_DRUM   = 4'd7;

  localparam logic [7:0] PAT_VAL [PAT_NUM][PAT_POS] = '{
    '{8'h7E, 8'h7F, 8'h09, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7E, 8'h7F, 8'h09, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7E, 8'h7F, 8'h09, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7E, 8'h7F, 8'h00, 8'h04, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h41, 8'h00, 8'h42, 8'h12, 8'h40, 8'h00, 8'h7F, 8'h00, 8'h41},
    '{8'h41, 8'h00, 8'h42, 8'h12, 8'h00, 8'h00, 8'h7F, 8'h00, 8'h01},
    '{8'h41, 8'h00, 8'h42, 8'h12, 8'h00, 8'h00, 8'h7F, 8'h01, 8'h00},
    '{8'h41, 8'h00, 8'h42, 8'h12, 8'h40, 8'h10, 8'h15, 8'h00, 8'h00},
    '{8'h43, 8'h00, 8'h4C, 8'h00, 8'h00, 8'h7E, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [7:0] PAT_MASK [PAT_NUM][PAT_POS] = '{
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
    '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
    '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
    '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hF0, 8'hFF, 8'h00, 8'h00},
    '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00}
  };

  // last body position of each prefix
  localparam logic [POS_W-1:0] PAT_END [PAT_NUM] = '{
    4'd3, 4'd3, 4'd3, 4'd6, 4'd8, 4'd8, 4'd8, 4'd7, 4'd6
  };

  localparam cmd_kind_t PAT_KIND [PAT_NUM] = '{
    CMD_RESET, CMD_RESET, CMD_RESET, CMD_VOLUME, CMD_RESET,
    CMD_RESET, CMD_RESET, CMD_DRUM, CMD_RESET
  };

  localparam sys_mode_t PAT_MODE [PAT_NUM] = '{
    MODE_GM1, MODE_GM2, MODE_GS, MODE_GM1, MODE_GS,
    MODE_SET1, MODE_SET2, MODE_GM1, MODE_XG
  };

endpackage

/* design/msd_if.sv */
// ----------------------------------------------------------------------------
// msd_in_if / msd_out_if
// Valid/ready channels for message bytes and decoded commands.
// ----------------------------------------------------------------------------
interface msd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       last_byte;

  modport source (output valid, output message_byte, output last_byte, input ready);
  modport sink   (input valid, input message_byte, input last_byte, output ready);
endinterface

interface msd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] command_kind;
  logic [2:0] system_mode;
  logic [7:0] volume_level;
  logic [3:0] part_number;
  logic       drum_enable;

  modport source (output valid, output command_kind, output system_mode,
                  output volume_level, output part_number, output drum_enable,
                  input ready);
  modport sink   (input valid, input command_kind, input system_mode,
                  input volume_level, input part_number, input drum_enable,
                  output ready);
endinterface

/* design/msd_match.sv */
// ----------------------------------------------------------------------------
// msd_match
// Checks one byte against all prefix patterns at its body position.
// ----------------------------------------------------------------------------
module msd_match
  import msd_pkg::*;
(
  input  logic [7:0]       msg_byte,
  input  logic [POS_W-1:0] pos,
  input  logic [PAT_NUM-1:0] alive,
  output msd_match_t       match
);

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(PAT_POS);

  logic             in_table;
  logic [POS_W-1:0] idx;
  logic [7:0]       mask;

  assign in_table = (pos < POS_LIMIT);
  assign idx      = in_table ? pos : '0;

  always_comb begin
    for (int k = 0; k < PAT_NUM; k++) begin
      mask = PAT_MASK[k][idx];
      match.alive[k] = alive[k];
      if (in_table && (pos <= PAT_END[k]) && (mask != 8'h00) &&
          ((msg_byte & mask) != PAT_VAL[k][idx])) begin
        match.alive[k] = 1'b0;
      end
      match.hit[k] = match.alive[k] && (pos >= PAT_END[k]);
    end
  end

endmodule

/* design/midi_sysex_command_decoder.sv */
// ----------------------------------------------------------------------------
// midi_sysex_command_decoder
// Decodes reset, master volume and drum part commands from exclusive messages.
// ----------------------------------------------------------------------------
// Feed the message body one byte per item, maker byte first, with last_byte
// set on the final byte. Items may arrive back to back while no result waits;
// only the flagged byte yields a command item, by way of the input register
// and then the compare and result register. A waiting result stalls a
// flagged byte in the input register, and the input with it; other bytes flow.
// State clears after each flagged byte, ready for the next message.
module midi_sysex_command_decoder
  import msd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  msd_in_if.sink           in_ch,
  msd_out_if.source        out_ch
);

  logic                s1_v_r;
  logic [7:0]          s1_byte_r;
  logic                s1_last_r;
  logic                s1_go;

  logic [POS_W-1:0]    pos_r;
  logic [PAT_NUM-1:0]  alive_r;
  logic [7:0]          vol_r,  vol_nxt;
  logic [3:0]          part_r, part_nxt;
  logic                drum_r, drum_nxt;
  msd_match_t          match;

  logic                out_v_r;
  cmd_kind_t           kind_r,  kind_nxt;
  sys_mode_t           mode_r,  mode_nxt;
  logic [7:0]          olvl_r,  olvl_nxt;
  logic [3:0]          opart_r, opart_nxt;
  logic                odrum_r, odrum_nxt;
  logic                found;

  assign s1_go       = s1_v_r && (!s1_last_r || !out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.message_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  msd_match u_match (
    .msg_byte (s1_byte_r),
    .pos      (pos_r),
    .alive    (alive_r),
    .match    (match)
  );

  assign vol_nxt  = (pos_r == POS_VOLUME) ? s1_byte_r : vol_r;
  assign part_nxt = (pos_r == POS_PART)   ? s1_byte_r[3:0] : part_r;
  assign drum_nxt = (pos_r == POS_DRUM)   ? (s1_byte_r != 8'h00) : drum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      alive_r <= '1;
      vol_r   <= '0;
      part_r  <= '0;
      drum_r  <= 1'b0;
    end else if (s1_go) begin
      if (s1_last_r) begin
        pos_r   <= '0;
        alive_r <= '1;
        vol_r   <= '0;
        part_r  <= '0;
        drum_r  <= 1'b0;
      end else begin
        pos_r   <= (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
        alive_r <= match.alive;
        vol_r   <= vol_nxt;
        part_r  <= part_nxt;
        drum_r  <= drum_nxt;
      end
    end
  end

  // first matching pattern in table order wins
  always_comb begin
    found     = 1'b0;
    kind_nxt  = CMD_NONE;
    mode_nxt  = MODE_GM1;
    olvl_nxt  = '0;
    opart_nxt = '0;
    odrum_nxt = 1'b0;
    for (int k = 0; k < PAT_NUM; k++) begin
      if (!found && match.hit[k]) begin
        found    = 1'b1;
        kind_nxt = PAT_KIND[k];
        unique case (PAT_KIND[k])
          CMD_RESET:  mode_nxt = PAT_MODE[k];
          CMD_VOLUME: olvl_nxt = vol_nxt;
          CMD_DRUM: begin
            opart_nxt = part_nxt;
            odrum_nxt = drum_nxt;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      kind_r  <= kind_nxt;
      mode_r  <= mode_nxt;
      olvl_r  <= olvl_nxt;
      opart_r <= opart_nxt;
      odrum_r <= odrum_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.command_kind = kind_r;
  assign out_ch.system_mode  = mode_r;
  assign out_ch.volume_level = olvl_r;
  assign out_ch.part_number  = opart_r;
  assign out_ch.drum_enable  = odrum_r;

endmodule

/* design/msd_checker.sv */
// ----------------------------------------------------------------------------
// msd_checker
// Port-level checks on the decoder's command items.
// ----------------------------------------------------------------------------
module msd_checker
  import msd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_command_kind,
  input logic [2:0] out_system_mode,
  input logic [7:0] out_volume_level,
  input logic [3:0] out_part_number,
  input logic       out_drum_enable
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command_kind) &&
      $stable(out_system_mode) && $stable(out_volume_level) &&
      $stable(out_part_number) && $stable(out_drum_enable))
    else $error("command item changed while stalled");

  a_mode_only_reset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command_kind != CMD_RESET) |-> out_system_mode == MODE_GM1)
    else $error("system mode set on non-reset command");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command_kind == CMD_RESET) |-> out_system_mode <= MODE_XG)
    else $error("system mode out of range");

  a_volume_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command_kind != CMD_VOLUME) |-> out_volume_level == 8'h00)
    else $error("volume set on non-volume command");

  a_drum_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command_kind != CMD_DRUM) |->
      (out_part_number == 4'h0) && !out_drum_enable)
    else $error("drum fields set on non-drum command");

endmodule

bind midi_sysex_command_decoder msd_checker u_msd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_command_kind (out_ch.command_kind),
  .out_system_mode  (out_ch.system_mode),
  .out_volume_level (out_ch.volume_level),
  .out_part_number  (out_ch.part_number),
  .out_drum_enable  (out_ch.drum_enable)
);

/* tb/sv/midi_sysex_command_decoder_tb.sv */
// ----------------------------------------------------------------------------
// midi_sysex_command_decoder_tb
// Self-checking bench for the exclusive message command decoder.
// Sends whole message bodies byte by byte: directed reset, volume, drum and
// edge-case messages, then random well-formed, damaged, cut-short, stretched
// and noise messages. A local decoder predicts each command item and a
// checker compares every output item with the oldest prediction. Both
// channels idle at random, with one steady stretch.
// ----------------------------------------------------------------------------
module midi_sysex_command_decoder_tb;
  import msd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPREFIX     = 9;
  localparam int NDEPTH      = 9;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 23;

  typedef logic [7:0] byte_list_t[$];

  typedef struct packed {
    cmd_kind_t   kind;
    sys_mode_t   mode;
    logic [7:0]  volume;
    logic [3:0]  part;
    logic        drum;
  } decoded_cmd_t;

  localparam logic [7:0] PREFIX_VAL [NPREFIX][NDEPTH] = '{
    '{8'h7E, 8'h7F, 8'h09, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7E, 8'h7F, 8'h09, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7E, 8'h7F, 8'h09, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7E, 8'h7F, 8'h00, 8'h04, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h41, 8'h00, 8'h42, 8'h12, 8'h40, 8'h00, 8'h7F, 8'h00, 8'h41},
    '{8'h41, 8'h00, 8'h42, 8'h12, 8'h00, 8'h00, 8'h7F, 8'h00, 8'h01},
    '{8'h41, 8'h00, 8'h42, 8'h12, 8'h00, 8'h00, 8'h7F, 8'h01, 8'h00},
    '{8'h41, 8'h00, 8'h42, 8'h12, 8'h40, 8'h10, 8'h15, 8'h00, 8'h00},
    '{8'h43, 8'h00, 8'h4C, 8'h00, 8'h00, 8'h7E, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [7:0] PREFIX_MASK [NPREFIX][NDEPTH] = '{
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
    '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
    '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
    '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hF0, 8'hFF, 8'h00, 8'h00},
    '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00}
  };

  localparam logic [3:0] PREFIX_LAST [NPREFIX] = '{
    4'd3, 4'd3, 4'd3, 4'd6, 4'd8, 4'd8, 4'd8, 4'd7, 4'd6
  };

  localparam cmd_kind_t PREFIX_KIND [NPREFIX] = '{
    CMD_RESET, CMD_RESET, CMD_RESET, CMD_VOLUME, CMD_RESET,
    CMD_RESET, CMD_RESET, CMD_DRUM, CMD_RESET
  };

  localparam sys_mode_t PREFIX_MODE [NPREFIX] = '{
    MODE_GM1, MODE_GM2, MODE_GS, MODE_GM1, MODE_GS,
    MODE_SET1, MODE_SET2, MODE_GM1, MODE_XG
  };

  logic clk = 1'b0;
  logic rst_n;

  msd_in_if  in_ch ();
  msd_out_if out_ch ();

  midi_sysex_command_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [3:0]         seen_pos;
  logic [NPREFIX-1:0] live_prefixes;
  logic [7:0]         cap_volume;
  logic [7:0]         cap_part;
  logic [7:0]         cap_drum_map;

  decoded_cmd_t decoded_q[$];
  decoded_cmd_t want;
  int           mismatch_count = 0;
  int           bytes_sent     = 0;
  int           cycle_count    = 0;
  bit           steady         = 1'b0;

  function automatic void clear_decode_state();
    seen_pos      = '0;
    live_prefixes = '1;
    cap_volume    = '0;
    cap_part      = '0;
    cap_drum_map  = '0;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output decoded_cmd_t cmd);
    logic [3:0] p;
    bit         found;
    p     = seen_pos;
    found = 1'b0;
    cmd   = '0;
    if (p < NDEPTH) begin
      for (int k = 0; k < NPREFIX; k++) begin
        if (p <= PREFIX_LAST[k] && PREFIX_MASK[k][p] != 8'h00 &&
            (b & PREFIX_MASK[k][p]) != PREFIX_VAL[k][p])
          live_prefixes[k] = 1'b0;
      end
      if (p == 4'd5) cap_part = b;
      if (p == 4'd6) cap_volume = b;
      if (p == 4'd7) cap_drum_map = b;
    end
    if (seen_pos != 4'hF) seen_pos = seen_pos + 4'd1;
    if (!last) return 1'b0;
    for (int k = 0; k < NPREFIX; k++) begin
      if (!found && live_prefixes[k] && p >= PREFIX_LAST[k]) begin
        found    = 1'b1;
        cmd.kind = PREFIX_KIND[k];
        case (PREFIX_KIND[k])
          CMD_RESET:  cmd.mode = PREFIX_MODE[k];
          CMD_VOLUME: cmd.volume = cap_volume;
          default: begin
            cmd.part = cap_part[3:0];
            cmd.drum = (cap_drum_map != 8'h00);
          end
        endcase
      end
    end
    clear_decode_state();
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    decoded_cmd_t cmd;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.message_byte <= b;
    in_ch.last_byte    <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    if (decode_byte(b, last, cmd)) decoded_q = {decoded_q, cmd};
  endtask

  task automatic send_message(input byte_list_t msg);
    for (int i = 0; i < msg.size(); i++)
      send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic byte_list_t build_message();
    byte_list_t msg;
    int         k;
    int         n;
    int         roll;
    msg = {};
    if ($urandom_range(99) < 25) begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(3) == 0)
          msg = {msg, PREFIX_VAL[$urandom_range(NPREFIX - 1)][i % NDEPTH]};
        else
          msg = {msg, 8'($urandom)};
      end
      return msg;
    end
    k = $urandom_range(NPREFIX - 1);
    for (int i = 0; i <= PREFIX_LAST[k]; i++)
      msg = {msg, PREFIX_VAL[k][i] | (8'($urandom) & ~PREFIX_MASK[k][i])};
    if (PREFIX_KIND[k] == CMD_DRUM && $urandom_range(1) == 0)
      msg[7] = 8'h00;
    if (PREFIX_KIND[k] == CMD_VOLUME && $urandom_range(3) == 0)
      msg[6] = $urandom_range(1) ? 8'hFF : 8'h00;
    roll = $urandom_range(99);
    if (roll < 15) begin
      n = $urandom_range(PREFIX_LAST[k]);
      msg[n] = msg[n] ^ (8'h01 << $urandom_range(7));
    end else if (roll < 25) begin
      n = $urandom_range(1, PREFIX_LAST[k]);
      while (msg.size() > n) void'(msg.pop_back());
    end
    if ($urandom_range(99) < 30) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) msg = {msg, 8'($urandom)};
    end
    return msg;
  endfunction

  task automatic test_reset_commands();
    send_message('{8'h7E, 8'h7F, 8'h09, 8'h01});
    send_message('{8'h7E, 8'h7F, 8'h09, 8'h03});
    send_message('{8'h7E, 8'h7F, 8'h09, 8'h02});
    send_message('{8'h41, 8'h10, 8'h42, 8'h12, 8'h40, 8'h00, 8'h7F, 8'h00, 8'h41});
    send_message('{8'h41, 8'h00, 8'h42, 8'h12, 8'h00, 8'h00, 8'h7F, 8'h00, 8'h01});
    send_message('{8'h41, 8'hFF, 8'h42, 8'h12, 8'h00, 8'h00, 8'h7F, 8'h01, 8'h00});
    send_message('{8'h43, 8'h10, 8'h4C, 8'h00, 8'h00, 8'h7E, 8'h00});
  endtask

  task automatic test_master_volume();
    send_message('{8'h7E, 8'h7F, 8'h7F, 8'h04, 8'h01, 8'h00, 8'h00});
    send_message('{8'h7E, 8'h7F, 8'h00, 8'h04, 8'h01, 8'h00, 8'h7F});
    send_message('{8'h7E, 8'h7F, 8'hFF, 8'h04, 8'h01, 8'h00, 8'hFF});
  endtask

  task automatic test_drum_part();
    send_message('{8'h41, 8'h10, 8'h42, 8'h12, 8'h40, 8'h10, 8'h15, 8'h00});
    send_message('{8'h41, 8'hFF, 8'h42, 8'h12, 8'h40, 8'h1F, 8'h15, 8'hFF});
    send_message('{8'h41, 8'h00, 8'h42, 8'h12, 8'h40, 8'h2F, 8'h15, 8'h01});
  endtask

  task automatic test_edge_messages();
    byte_list_t msg;
    send_message('{8'h7E, 8'h7F, 8'h09});
    send_message('{8'hFF});
    send_message('{8'h00});
    send_message('{8'h7E, 8'h7F, 8'h09, 8'h05});
    msg = '{8'h7E, 8'h7F, 8'h09, 8'h01};
    repeat (16) msg = {msg, 8'hFF};
    send_message(msg);
  endtask

  task automatic test_random_traffic();
    int count;
    count = 0;
    while (bytes_sent < 390) begin
      steady = (count >= 10 && count < 22);
      if (count == 5) wait_for_results();
      send_message(build_message());
      count++;
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected command item: kind %0d mode %0d vol %02h part %0h drum %0b",
                   out_ch.command_kind, out_ch.system_mode, out_ch.volume_level,
                   out_ch.part_number, out_ch.drum_enable);
        mismatch_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_ch.command_kind !== want.kind || out_ch.system_mode !== want.mode ||
            out_ch.volume_level !== want.volume || out_ch.part_number !== want.part ||
            out_ch.drum_enable !== want.drum) begin
          if (mismatch_count < 10)
            $display("mismatch: expected kind %0d mode %0d vol %02h part %0h drum %0b, %s",
                     want.kind, want.mode, want.volume, want.part, want.drum,
                     $sformatf("got kind %0d mode %0d vol %02h part %0h drum %0b",
                               out_ch.command_kind, out_ch.system_mode,
                               out_ch.volume_level, out_ch.part_number,
                               out_ch.drum_enable));
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.message_byte = 8'h00;
    in_ch.last_byte    = 1'b0;
    out_ch.ready       = 1'b0;
    clear_decode_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_commands();
    wait_for_results();
    test_master_volume();
    test_drum_part();
    wait_for_results();
    test_edge_messages();
    test_random_traffic();

    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
